// ===== rtl/ps2mct_pkg.sv =====
package ps2mct_pkg;

   localparam int BYTE_W   = 8;
   localparam int POS_W    = 10;
   localparam int SENS_W   = 4;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   // Status bits of a controller poll.
   localparam int STATUS_READY_BIT = 0;
   localparam int STATUS_AUX_BIT   = 5;

   // Bits of the first packet byte.
   localparam int HEAD_LEFT_BIT = 0;
   localparam int HEAD_SYNC_BIT = 3;

   localparam logic [POS_W-1:0]  MAX_X_RESET       = POS_W'(784);
   localparam logic [POS_W-1:0]  MAX_Y_RESET       = POS_W'(584);
   localparam logic [SENS_W-1:0] SENSITIVITY_RESET = SENS_W'(1);
   localparam logic [POS_W-1:0]  POS_X_RESET       = POS_W'(400);
   localparam logic [POS_W-1:0]  POS_Y_RESET       = POS_W'(300);

   // Register indexes (byte address bits [3:2]).
   localparam logic [1:0] REG_MAX_X       = 2'd0;
   localparam logic [1:0] REG_MAX_Y       = 2'd1;
   localparam logic [1:0] REG_SENSITIVITY = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0]  max_x;
      logic [POS_W-1:0]  max_y;
      logic [SENS_W-1:0] sensitivity;
   } cfg_type;

endpackage

// ===== rtl/ps2mct_if.sv =====
interface ps2mct_req_if;
   logic                           valid;
   logic                           ready;
   logic [ps2mct_pkg::BYTE_W-1:0]  status_byte;
   logic [ps2mct_pkg::BYTE_W-1:0]  data_byte;

   modport source (output valid, output status_byte, output data_byte, input ready);
   modport sink   (input valid, input status_byte, input data_byte, output ready);
endinterface

interface ps2mct_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ps2mct_pkg::POS_W-1:0]  cursor_x;
   logic [ps2mct_pkg::POS_W-1:0]  cursor_y;
   logic                          left_button;

   modport source (output valid, output cursor_x, output cursor_y, output left_button,
                   input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input left_button,
                   output ready);
endinterface

// ===== rtl/ps2mct_csr.sv =====
module ps2mct_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ps2mct_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [ps2mct_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [ps2mct_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                              csr_pready,
   output ps2mct_pkg::cfg_type               cfg
);

   ps2mct_pkg::cfg_type cfg_ff;
   ps2mct_pkg::cfg_type cfg_in;
   logic                write_en;
   logic [1:0]          reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            ps2mct_pkg::REG_MAX_X:
               cfg_in.max_x = csr_pwdata[ps2mct_pkg::POS_W-1:0];
            ps2mct_pkg::REG_MAX_Y:
               cfg_in.max_y = csr_pwdata[ps2mct_pkg::POS_W-1:0];
            ps2mct_pkg::REG_SENSITIVITY:
               cfg_in.sensitivity = csr_pwdata[ps2mct_pkg::SENS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         ps2mct_pkg::REG_MAX_X:
            csr_prdata = ps2mct_pkg::CSR_DW'(cfg_ff.max_x);
         ps2mct_pkg::REG_MAX_Y:
            csr_prdata = ps2mct_pkg::CSR_DW'(cfg_ff.max_y);
         ps2mct_pkg::REG_SENSITIVITY:
            csr_prdata = ps2mct_pkg::CSR_DW'(cfg_ff.sensitivity);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_x       <= ps2mct_pkg::MAX_X_RESET;
         cfg_ff.max_y       <= ps2mct_pkg::MAX_Y_RESET;
         cfg_ff.sensitivity <= ps2mct_pkg::SENSITIVITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/ps2mct_core.sv =====
module ps2mct_core (
   input  logic                 clock,
   input  logic                 reset,
   input  ps2mct_pkg::cfg_type  cfg,
   ps2mct_req_if.sink           req_chan,
   ps2mct_rsp_if.source         rsp_chan
);

   typedef enum logic [1:0] {
      IDX_HEAD,
      IDX_DX,
      IDX_DY
   } byte_index_type;

   localparam int SUM_W = ps2mct_pkg::POS_W + 3;

   byte_index_type                     byte_index_ff, byte_index_in;
   logic                               in_valid_ff, in_valid_in;
   logic [ps2mct_pkg::BYTE_W-1:0]      status_ff, status_in;
   logic [ps2mct_pkg::BYTE_W-1:0]      data_ff, data_in;
   logic [ps2mct_pkg::BYTE_W-1:0]      head_ff, head_in;
   logic [ps2mct_pkg::BYTE_W-1:0]      dx_byte_ff, dx_byte_in;
   logic [ps2mct_pkg::POS_W-1:0]       pos_x_ff, pos_x_in;
   logic [ps2mct_pkg::POS_W-1:0]       pos_y_ff, pos_y_in;
   logic                               button_ff, button_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic                               out_free;
   logic                               take;
   logic                               use_byte;
   logic                               emit;
   logic signed [SUM_W-1:0]            step_x, step_y;
   logic signed [SUM_W-1:0]            sum_x, sum_y;

   function automatic logic [ps2mct_pkg::POS_W-1:0] clamp_pos(
      input logic signed [SUM_W-1:0]      v,
      input logic [ps2mct_pkg::POS_W-1:0] limit
   );
      logic [ps2mct_pkg::POS_W-1:0] r;
      if (v[SUM_W-1]) begin
         r = '0;
      end else if (v[SUM_W-2:0] > (SUM_W-1)'(limit)) begin
         r = limit;
      end else begin
         r = v[ps2mct_pkg::POS_W-1:0];
      end
      return r;
   endfunction

   // The input register is drained whenever the result register can take a value.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign take           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || take;
   assign use_byte       = take && status_ff[ps2mct_pkg::STATUS_READY_BIT]
                                && status_ff[ps2mct_pkg::STATUS_AUX_BIT];
   assign emit           = use_byte && (byte_index_ff == IDX_DY);

   assign step_x = SUM_W'($signed(dx_byte_ff)) * SUM_W'($signed({1'b0, cfg.sensitivity}));
   assign step_y = SUM_W'($signed(data_ff)) * SUM_W'($signed({1'b0, cfg.sensitivity}));
   assign sum_x  = $signed({3'b000, pos_x_ff}) + step_x;
   assign sum_y  = $signed({3'b000, pos_y_ff}) - step_y;

   always_comb begin
      in_valid_in   = in_valid_ff;
      status_in     = status_ff;
      data_in       = data_ff;
      byte_index_in = byte_index_ff;
      head_in       = head_ff;
      dx_byte_in    = dx_byte_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      button_in     = button_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      if (take) begin
         in_valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
         status_in   = req_chan.status_byte;
         data_in     = req_chan.data_byte;
      end

      if (use_byte) begin
         unique case (byte_index_ff)
            IDX_HEAD: begin
               // A header without the sync bit is dropped to regain packet alignment.
               if (data_ff[ps2mct_pkg::HEAD_SYNC_BIT]) begin
                  head_in       = data_ff;
                  byte_index_in = IDX_DX;
               end
            end
            IDX_DX: begin
               dx_byte_in    = data_ff;
               byte_index_in = IDX_DY;
            end
            default: begin
               byte_index_in = IDX_HEAD;
               button_in     = head_ff[ps2mct_pkg::HEAD_LEFT_BIT];
               pos_x_in      = clamp_pos(sum_x, cfg.max_x);
               pos_y_in      = clamp_pos(sum_y, cfg.max_y);
               rsp_valid_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         byte_index_ff <= IDX_HEAD;
         head_ff       <= '0;
         dx_byte_ff    <= '0;
         pos_x_ff      <= ps2mct_pkg::POS_X_RESET;
         pos_y_ff      <= ps2mct_pkg::POS_Y_RESET;
         button_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         byte_index_ff <= byte_index_in;
         head_ff       <= head_in;
         dx_byte_ff    <= dx_byte_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         button_ff     <= button_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      status_ff <= status_in;
      data_ff   <= data_in;
   end

   // The cursor registers double as the result payload.
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cursor_x    = pos_x_ff;
   assign rsp_chan.cursor_y    = pos_y_ff;
   assign rsp_chan.left_button = button_ff;

   a_idx_legal: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff == IDX_HEAD || byte_index_ff == IDX_DX || byte_index_ff == IDX_DY)
      else $error("byte index left the packet sequence");

   a_emit_resets_idx: assert property (@(posedge clock) disable iff (reset)
      emit |=> byte_index_ff == IDX_HEAD && rsp_valid_ff)
      else $error("completed packet did not restart assembly or raise a result");

   a_clamp_x: assert property (@(posedge clock) disable iff (reset)
      emit |=> pos_x_ff <= $past(cfg.max_x) && pos_y_ff <= $past(cfg.max_y))
      else $error("cursor left the clamp window");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !take |=> in_valid_ff && $stable(data_ff))
      else $error("held poll was lost");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !emit)
      else $error("result register overwritten while stalled");

endmodule

// ===== rtl/ps2_mouse_cursor_tracker.sv =====
// PS/2 mouse cursor tracker.
// The request channel carries one controller poll per transaction: a status
// byte and a data byte. Polls whose status lacks data ready or the auxiliary
// flag are consumed and produce nothing. Accepted bytes are assembled into
// three-byte mouse packets; a first byte without its sync bit is dropped.
// Each completed packet yields one response transaction with the clamped
// cursor position and the left button state.
// A poll is registered on acceptance and processed once the result register
// can take a value; the cursor from the third byte is then registered there.
// One poll is accepted every cycle while the response is not stalled; the
// rate is set by the single add-and-clamp stage between the input register
// and the result register. When the response is stalled, no poll is
// processed: the input register holds one more poll and the request channel
// stalls once that register is full.
// Reset places the cursor at (400, 300), restarts packet assembly and loads
// the clamp limits 784 and 584 with sensitivity one. The limits and the
// sensitivity are written through the register port; the user must write
// them only while the block is idle; the block itself does not enforce it.
module ps2_mouse_cursor_tracker (
   input  logic                           clock,
   input  logic                           reset,
   ps2mct_req_if.sink                     req_chan,
   ps2mct_rsp_if.source                   rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ps2mct_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ps2mct_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ps2mct_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                           csr_pready
);

   ps2mct_pkg::cfg_type cfg;

   ps2mct_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ps2mct_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/ps2mct_cursor_audit.sv =====
module ps2mct_cursor_audit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           poll_valid,
   input  logic                           poll_ready,
   input  logic [ps2mct_pkg::BYTE_W-1:0]  status_byte,
   input  logic [ps2mct_pkg::BYTE_W-1:0]  data_byte,
   input  logic                           cursor_valid,
   input  logic                           cursor_ready,
   input  logic [ps2mct_pkg::POS_W-1:0]   cursor_x,
   input  logic [ps2mct_pkg::POS_W-1:0]   cursor_y,
   input  logic                           left_button,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [ps2mct_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ps2mct_pkg::CSR_DW-1:0]  csr_pwdata,
   output int                             mismatches,
   output int                             cursors_pending,
   output int                             cursors_checked
);

   localparam int BYTE_W = ps2mct_pkg::BYTE_W;
   localparam int POS_W  = ps2mct_pkg::POS_W;
   localparam int SENS_W = ps2mct_pkg::SENS_W;

   typedef enum logic [1:0] {AWAIT_HEAD, AWAIT_DX, AWAIT_DY} packet_slot_type;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic             button;
   } cursor_type;

   ps2mct_pkg::cfg_type limits;
   packet_slot_type     packet_slot;
   logic [BYTE_W-1:0]   head_latched;
   logic [BYTE_W-1:0]   dx_latched;
   logic [POS_W-1:0]    track_x;
   logic [POS_W-1:0]    track_y;
   logic                button_held;
   cursor_type          due_cursors[$];

   function automatic logic [POS_W-1:0] clamp_to(input int v, input logic [POS_W-1:0] limit);
      if (v < 0) return '0;
      if (v > int'(limit)) return limit;
      return POS_W'(v);
   endfunction

   // Feeds one poll into the packet assembler; returns 1 when a packet completes.
   function automatic bit advance_packet(input logic [BYTE_W-1:0] status,
                                         input logic [BYTE_W-1:0] data,
                                         output cursor_type moved);
      int sens;
      int nx;
      int ny;
      sens  = int'(limits.sensitivity);
      moved = '0;
      if (!(status[ps2mct_pkg::STATUS_READY_BIT] && status[ps2mct_pkg::STATUS_AUX_BIT]))
         return 1'b0;
      if (packet_slot == AWAIT_HEAD) begin
         // Without the sync bit the byte cannot start a packet.
         if (!data[ps2mct_pkg::HEAD_SYNC_BIT]) return 1'b0;
         head_latched = data;
         packet_slot  = AWAIT_DX;
         return 1'b0;
      end
      if (packet_slot == AWAIT_DX) begin
         dx_latched  = data;
         packet_slot = AWAIT_DY;
         return 1'b0;
      end
      packet_slot = AWAIT_HEAD;
      button_held = head_latched[ps2mct_pkg::HEAD_LEFT_BIT];
      nx = int'(track_x) + int'($signed(dx_latched)) * sens;
      ny = int'(track_y) - int'($signed(data)) * sens;
      track_x = clamp_to(nx, limits.max_x);
      track_y = clamp_to(ny, limits.max_y);
      moved = '{x: track_x, y: track_y, button: button_held};
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      cursor_type seen;
      cursor_type due;
      cursor_type fresh;
      if (reset) begin
         limits          = '{max_x: ps2mct_pkg::MAX_X_RESET,
                             max_y: ps2mct_pkg::MAX_Y_RESET,
                             sensitivity: ps2mct_pkg::SENSITIVITY_RESET};
         packet_slot     = AWAIT_HEAD;
         head_latched    = '0;
         dx_latched      = '0;
         track_x         = ps2mct_pkg::POS_X_RESET;
         track_y         = ps2mct_pkg::POS_Y_RESET;
         button_held     = 1'b0;
         mismatches      = 0;
         cursors_checked = 0;
         due_cursors.delete();
      end else begin
         if (cursor_valid && cursor_ready) begin
            seen = '{x: cursor_x, y: cursor_y, button: left_button};
            if (due_cursors.size() == 0) begin
               note_mismatch("unexpected transaction, cursor_x", -1, int'(seen.x));
            end else begin
               due = due_cursors.pop_front();
               cursors_checked++;
               if (seen.x !== due.x) note_mismatch("cursor_x", int'(due.x), int'(seen.x));
               if (seen.y !== due.y) note_mismatch("cursor_y", int'(due.y), int'(seen.y));
               if (seen.button !== due.button)
                  note_mismatch("left_button", int'(due.button), int'(seen.button));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               ps2mct_pkg::REG_MAX_X:       limits.max_x       = csr_pwdata[POS_W-1:0];
               ps2mct_pkg::REG_MAX_Y:       limits.max_y       = csr_pwdata[POS_W-1:0];
               ps2mct_pkg::REG_SENSITIVITY: limits.sensitivity = csr_pwdata[SENS_W-1:0];
               default: ;
            endcase
         end
         if (poll_valid && poll_ready) begin
            if (advance_packet(status_byte, data_byte, fresh)) due_cursors.push_back(fresh);
         end
      end
      cursors_pending = due_cursors.size();
   end

endmodule

// ===== tb/tb_ps2_mouse_cursor_tracker.sv =====
module tb_ps2_mouse_cursor_tracker;

   localparam int BYTE_W = ps2mct_pkg::BYTE_W;
   localparam int CSR_AW = ps2mct_pkg::CSR_AW;
   localparam int CSR_DW = ps2mct_pkg::CSR_DW;

   localparam logic [BYTE_W-1:0] MOUSE_FLAGS =
      BYTE_W'((1 << ps2mct_pkg::STATUS_READY_BIT) | (1 << ps2mct_pkg::STATUS_AUX_BIT));
   localparam logic [BYTE_W-1:0] SYNC_MASK   = BYTE_W'(1 << ps2mct_pkg::HEAD_SYNC_BIT);

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int mismatches;
   int cursors_pending;
   int cursors_checked;
   int poll_idle_pct   = 22;
   int cursor_idle_pct = 83;
   int cursor_hold     = 0;
   int mouse_polls     = 0;
   int stray_polls     = 0;
   int settings_done   = 0;

   ps2mct_req_if poll_bus ();
   ps2mct_rsp_if cursor_bus ();

   always #5 clock = ~clock;

   ps2_mouse_cursor_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (poll_bus),
      .rsp_chan    (cursor_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ps2mct_cursor_audit audit (
      .clock           (clock),
      .reset           (reset),
      .poll_valid      (poll_bus.valid),
      .poll_ready      (poll_bus.ready),
      .status_byte     (poll_bus.status_byte),
      .data_byte       (poll_bus.data_byte),
      .cursor_valid    (cursor_bus.valid),
      .cursor_ready    (cursor_bus.ready),
      .cursor_x        (cursor_bus.cursor_x),
      .cursor_y        (cursor_bus.cursor_y),
      .left_button     (cursor_bus.left_button),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .mismatches      (mismatches),
      .cursors_pending (cursors_pending),
      .cursors_checked (cursors_checked)
   );

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      cursor_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (cursor_hold > 0) begin
            cursor_bus.ready = 1'b0;
            cursor_hold--;
         end else begin
            cursor_bus.ready = ($urandom_range(99) >= cursor_idle_pct);
         end
      end
   end

   function automatic logic [BYTE_W-1:0] mouse_status();
      return BYTE_W'($urandom) | MOUSE_FLAGS;
   endfunction

   function automatic logic [BYTE_W-1:0] stray_status();
      logic [BYTE_W-1:0] s;
      s = BYTE_W'($urandom);
      case ($urandom_range(2))
         0: s[ps2mct_pkg::STATUS_READY_BIT] = 1'b0;
         1: s[ps2mct_pkg::STATUS_AUX_BIT] = 1'b0;
         default: begin
            s[ps2mct_pkg::STATUS_READY_BIT] = 1'b0;
            s[ps2mct_pkg::STATUS_AUX_BIT]   = 1'b0;
         end
      endcase
      return s;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_delta();
      if ($urandom_range(3) != 0) return BYTE_W'($urandom);
      case ($urandom_range(4))
         0: return 8'h00;
         1: return 8'h7F;
         2: return 8'h80;
         3: return 8'hFF;
         default: return 8'h01;
      endcase
   endfunction

   task automatic send_poll(input logic [BYTE_W-1:0] status, input logic [BYTE_W-1:0] data);
      while ($urandom_range(99) < poll_idle_pct) @(negedge clock);
      poll_bus.valid       = 1'b1;
      poll_bus.status_byte = status;
      poll_bus.data_byte   = data;
      @(posedge clock);
      while (!poll_bus.ready) @(posedge clock);
      @(negedge clock);
      poll_bus.valid = 1'b0;
      if (status[ps2mct_pkg::STATUS_READY_BIT] && status[ps2mct_pkg::STATUS_AUX_BIT])
         mouse_polls++;
      else stray_polls++;
   endtask

   // Occasionally a poll from the keyboard side or an empty poll slips in between bytes.
   task automatic send_mouse_byte(input logic [BYTE_W-1:0] data);
      if ($urandom_range(9) == 0) send_poll(stray_status(), BYTE_W'($urandom));
      send_poll(mouse_status(), data);
   endtask

   task automatic send_packet();
      send_mouse_byte(BYTE_W'($urandom) | SYNC_MASK);
      send_mouse_byte(pick_delta());
      send_mouse_byte(pick_delta());
   endtask

   task automatic random_phase(input int polls_wanted);
      int target;
      int pick;
      target = mouse_polls + polls_wanted;
      while (mouse_polls < target) begin
         pick = $urandom_range(99);
         if (pick < 78) begin
            send_packet();
         end else if (pick < 88) begin
            send_poll(stray_status(), BYTE_W'($urandom));
         end else if (pick < 94) begin
            send_mouse_byte(BYTE_W'($urandom) & ~SYNC_MASK);
         end else begin
            // A packet cut short leaves the assembler out of step with the stream.
            send_mouse_byte(BYTE_W'($urandom) | SYNC_MASK);
            if ($urandom_range(1) == 1) send_mouse_byte(pick_delta());
         end
      end
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [CSR_DW-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_AW'({index, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic apply_setting(input int mx, input int my, input int sens);
      write_reg(ps2mct_pkg::REG_MAX_X, CSR_DW'(mx));
      write_reg(ps2mct_pkg::REG_MAX_Y, CSR_DW'(my));
      write_reg(ps2mct_pkg::REG_SENSITIVITY, CSR_DW'(sens));
      settings_done++;
   endtask

   // The last poll may still be in the pipeline even if it yields nothing.
   task automatic wait_drained();
      while (cursors_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      poll_bus.valid       = 1'b0;
      poll_bus.status_byte = '0;
      poll_bus.data_byte   = '0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Polls without both the ready and auxiliary flags are ignored.
      send_poll(8'h01, 8'h09);
      send_poll(8'h20, 8'h08);
      send_poll(8'h00, 8'hFF);
      send_poll(8'hDE, 8'hFF);
      // Bytes without the sync bit cannot start a packet.
      send_poll(8'h21, 8'h00);
      send_poll(8'hFF, 8'hF7);
      // Header with every flag set, extreme deltas both ways.
      send_poll(8'hFF, 8'hFF);
      send_poll(8'h21, 8'h7F);
      send_poll(8'h3F, 8'h80);
      send_poll(8'h21, 8'h08);
      send_poll(8'hE1, 8'h80);
      send_poll(8'h21, 8'h7F);
      send_poll(8'h21, 8'h09);
      send_poll(8'h21, 8'h00);
      send_poll(8'h21, 8'h00);
      // Overflow bits in the header do not affect the deltas.
      send_poll(8'h21, 8'hC9);
      send_poll(8'h21, 8'hFF);
      send_poll(8'h21, 8'h01);
      random_phase(250);
      wait_drained();

      apply_setting(1023, 1023, 15);
      random_phase(250);
      wait_drained();

      poll_idle_pct   = 83;
      cursor_idle_pct = 22;
      // Limits drop below the cursor and movement is scaled to nothing.
      apply_setting(0, 0, 0);
      random_phase(100);
      wait_drained();
      apply_setting(511, 300, 7);
      random_phase(250);
      wait_drained();

      poll_idle_pct   = 0;
      cursor_idle_pct = 0;
      apply_setting($urandom_range(1023), $urandom_range(1023), $urandom_range(15, 1));
      random_phase(150);
      cursor_hold = 60;
      repeat (12) send_packet();
      wait_drained();
      random_phase(150);
      wait_drained();

      $display("Sent %0d mouse polls and %0d ignored polls; %0d cursor updates checked.",
               mouse_polls, stray_polls, cursors_checked);
      $display("Covered %0d register settings and stalls on both sides of the block.",
               settings_done);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
